### sv/sbsi_pkg.sv
// Package for the segment versus box slab test: field widths, payload
// structs, lane and comparison records, and the pairing tables.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sbsi_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int NUM_AXES      = 3;

    // Slab numerators need two growth bits plus sign; the direction magnitude one.
    localparam int N_W   = COORD_WIDTH + 3;
    localparam int DEN_W = COORD_WIDTH + 1;

    // Cross checks: entry fraction of axis CROSS_LO[k] against exit of CROSS_HI[k].
    localparam int NUM_CROSS = NUM_AXES * (NUM_AXES - 1);
    localparam int CROSS_LO [NUM_CROSS] = '{0, 0, 1, 1, 2, 2};
    localparam int CROSS_HI [NUM_CROSS] = '{1, 2, 0, 2, 0, 1};

    // Entry fraction pairs, first index always below the second.
    localparam int NUM_PAIRS = 3;
    localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 1};
    localparam int PAIR_B [NUM_PAIRS] = '{1, 2, 2};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] start_z;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] end_z;
        logic signed [COORD_WIDTH-1:0] box_center_x;
        logic signed [COORD_WIDTH-1:0] box_center_y;
        logic signed [COORD_WIDTH-1:0] box_center_z;
        logic [COORD_WIDTH-2:0]        box_half_x;
        logic [COORD_WIDTH-2:0]        box_half_y;
        logic [COORD_WIDTH-2:0]        box_half_z;
    } in_t;

    typedef struct packed {
        logic                     hit;
        logic [FRACTION_BITS:0]   entry_fraction;
    } out_t;

    typedef struct packed {
        logic                    active;
        logic                    contain;
        logic signed [N_W-1:0]   n1;
        logic signed [N_W-1:0]   n2;
        logic [DEN_W-1:0]        den;
    } lane_t;

    typedef struct packed {
        logic [NUM_CROSS-1:0] cross_gt;
        logic [NUM_PAIRS-1:0] low_gt;
        logic [NUM_PAIRS-1:0] low_lt;
    } cmp_res_t;

    typedef struct packed {
        logic                  hit;
        logic signed [N_W-1:0] n;
        logic [DEN_W-1:0]      den;
    } sel_t;

endpackage

`default_nettype wire

### sv/sbsi_lane.sv
// One axis lane: slab bounds, direction, and the ordered entry and exit
// numerators over the direction magnitude. Uses sbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsi_lane
    import sbsi_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [COORD_WIDTH-1:0] p0,
    input  wire logic signed [COORD_WIDTH-1:0] p1,
    input  wire logic signed [COORD_WIDTH-1:0] c,
    input  wire logic [COORD_WIDTH-2:0]        h,
    output lane_t                              lane_reg
);

    logic signed [N_W-1:0] p0e, p1e, ce, he, lo, hi;
    logic                  neg;
    logic signed [N_W-1:0] dn;
    lane_t                 lane_next;

    always_comb begin
        p0e = N_W'(p0);
        p1e = N_W'(p1);
        ce  = N_W'(c);
        he  = $signed({4'b0000, h});
        lo  = ce - he;
        hi  = ce + he;
        neg = p1 < p0;
        dn  = neg ? (p0e - p1e) : (p1e - p0e);
        lane_next.active  = p1 != p0;
        lane_next.contain = (p0e >= lo) && (p0e <= hi);
        lane_next.den     = dn[DEN_W-1:0];
        // A negative direction flips the signs, which also swaps the bounds.
        lane_next.n1      = neg ? (p0e - hi) : (lo - p0e);
        lane_next.n2      = neg ? (p0e - lo) : (hi - p0e);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

endmodule

`default_nettype wire

### sv/sbsi_cmp.sv
// Three-stage exact comparison of two fractions an/ad and bn/bd with
// positive denominators: split cross products, sums, then the sign test.
// Uses sbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsi_cmp
    import sbsi_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic [2:0]            en,
    input  wire logic signed [N_W-1:0] an,
    input  wire logic [DEN_W-1:0]      ad,
    input  wire logic signed [N_W-1:0] bn,
    input  wire logic [DEN_W-1:0]      bd,
    output logic                       gt_reg,
    output logic                       lt_reg
);

    localparam int OW = N_W - 1;
    localparam int HB = (OW + 1) / 2;
    localparam int UB = OW - HB;
    localparam int PW = 2 * OW;

    logic [OW-1:0] ma, mb, da, db;
    logic [1:0]    ra, rb;

    // Sign rank: 2 positive, 1 zero, 0 negative.
    always_comb begin
        ma = an[N_W-1] ? OW'(-an) : OW'(an);
        mb = bn[N_W-1] ? OW'(-bn) : OW'(bn);
        da = OW'(ad);
        db = OW'(bd);
        ra = an[N_W-1] ? 2'd0 : ((an == '0) ? 2'd1 : 2'd2);
        rb = bn[N_W-1] ? 2'd0 : ((bn == '0) ? 2'd1 : 2'd2);
    end

    logic [2*HB-1:0]    x_ll_reg, y_ll_reg;
    logic [HB+UB-1:0]   x_lh_reg, x_hl_reg, y_lh_reg, y_hl_reg;
    logic [2*UB-1:0]    x_hh_reg, y_hh_reg;
    logic [1:0]         ra1_reg, rb1_reg, ra2_reg, rb2_reg;
    logic [PW-1:0]      x_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x_ll_reg <= ma[HB-1:0] * db[HB-1:0];
            x_lh_reg <= ma[HB-1:0] * db[OW-1:HB];
            x_hl_reg <= ma[OW-1:HB] * db[HB-1:0];
            x_hh_reg <= ma[OW-1:HB] * db[OW-1:HB];
            y_ll_reg <= mb[HB-1:0] * da[HB-1:0];
            y_lh_reg <= mb[HB-1:0] * da[OW-1:HB];
            y_hl_reg <= mb[OW-1:HB] * da[HB-1:0];
            y_hh_reg <= mb[OW-1:HB] * da[OW-1:HB];
            ra1_reg  <= ra;
            rb1_reg  <= rb;
        end
        if (en[1]) begin
            x_reg   <= PW'(x_ll_reg) + (PW'(x_lh_reg) << HB) + (PW'(x_hl_reg) << HB)
                     + (PW'(x_hh_reg) << (2 * HB));
            y_reg   <= PW'(y_ll_reg) + (PW'(y_lh_reg) << HB) + (PW'(y_hl_reg) << HB)
                     + (PW'(y_hh_reg) << (2 * HB));
            ra2_reg <= ra1_reg;
            rb2_reg <= rb1_reg;
        end
    end

    logic gt_next, lt_next;

    always_comb begin
        if (ra2_reg != rb2_reg) begin
            gt_next = ra2_reg > rb2_reg;
            lt_next = ra2_reg < rb2_reg;
        end else if (ra2_reg == 2'd1) begin
            gt_next = 1'b0;
            lt_next = 1'b0;
        end else if (ra2_reg == 2'd2) begin
            gt_next = x_reg > y_reg;
            lt_next = x_reg < y_reg;
        end else begin
            gt_next = x_reg < y_reg;
            lt_next = x_reg > y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            gt_reg <= gt_next;
            lt_reg <= lt_next;
        end
    end

endmodule

`default_nettype wire

### sv/sbsi_merge.sv
// Merging stage: combines the lanes and the comparison results into the
// hit flag and the largest entry fraction. Uses sbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsi_merge
    import sbsi_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     en,
    input  lane_t         lanes [NUM_AXES],
    input  cmp_res_t      res,
    output sel_t          sel_reg
);

    logic beat [NUM_AXES][NUM_AXES];
    logic [NUM_AXES-1:0] cand, best;
    logic found;
    sel_t sel_next;

    always_comb begin
        sel_next.hit = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (!lanes[a].active) begin
                if (!lanes[a].contain) sel_next.hit = 1'b0;
            end else begin
                if (lanes[a].n1 > $signed({2'b00, lanes[a].den})) sel_next.hit = 1'b0;
                if (lanes[a].n2[N_W-1]) sel_next.hit = 1'b0;
            end
        end
        for (int k = 0; k < NUM_CROSS; k++) begin
            if (lanes[CROSS_LO[k]].active && lanes[CROSS_HI[k]].active && res.cross_gt[k])
                sel_next.hit = 1'b0;
        end

        for (int i = 0; i < NUM_AXES; i++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                beat[i][j] = 1'b0;
            end
        end
        for (int p = 0; p < NUM_PAIRS; p++) begin
            beat[PAIR_A[p]][PAIR_B[p]] = res.low_gt[p];
            beat[PAIR_B[p]][PAIR_A[p]] = res.low_lt[p];
        end

        // Only entries above zero can raise the interval start.
        for (int i = 0; i < NUM_AXES; i++) begin
            cand[i] = lanes[i].active && !lanes[i].n1[N_W-1] && (lanes[i].n1 != '0);
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            best[i] = cand[i];
            for (int j = 0; j < NUM_AXES; j++) begin
                if (j != i && cand[j] && beat[j][i]) best[i] = 1'b0;
            end
        end

        sel_next.n   = '0;
        sel_next.den = DEN_W'(1);
        found        = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (best[i] && !found) begin
                sel_next.n   = lanes[i].n1;
                sel_next.den = lanes[i].den;
                found        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel_reg <= sel_next;
        end
    end

endmodule

`default_nettype wire

### sv/sbsi_frac.sv
// Restoring divider pipeline that turns the selected entry fraction into
// rounded unsigned Q1.FRACTION_BITS, one quotient bit a stage. Uses sbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsi_frac
    import sbsi_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic [FRACTION_BITS:0] en,
    input  sel_t                        sel,
    output out_t                        out_reg
);

    localparam int F  = FRACTION_BITS;
    localparam int RW = DEN_W + 1;

    logic [RW-1:0]    r_reg    [F];
    logic [F-1:0]     q_reg    [F];
    logic [DEN_W-1:0] d_reg    [F];
    logic             full_reg [F];
    logic             hit_reg  [F];

    for (genvar k = 0; k < F; k++) begin : g_step
        logic [RW-1:0]    r_src, r_sh;
        logic [F-1:0]     q_src;
        logic [DEN_W-1:0] d_src;
        logic             full_src, hit_src, take;

        if (k == 0) begin : g_first
            assign r_src    = {1'b0, sel.n[DEN_W-1:0]};
            assign q_src    = '0;
            assign d_src    = sel.den;
            assign full_src = sel.n >= $signed({2'b00, sel.den});
            assign hit_src  = sel.hit;
        end else begin : g_next
            assign r_src    = r_reg[k-1];
            assign q_src    = q_reg[k-1];
            assign d_src    = d_reg[k-1];
            assign full_src = full_reg[k-1];
            assign hit_src  = hit_reg[k-1];
        end

        assign r_sh = {r_src[RW-2:0], 1'b0};
        assign take = r_sh >= {1'b0, d_src};

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                r_reg[k]    <= take ? (r_sh - {1'b0, d_src}) : r_sh;
                q_reg[k]    <= {q_src[F-2:0], take};
                d_reg[k]    <= d_src;
                full_reg[k] <= full_src;
                hit_reg[k]  <= hit_src;
            end
        end
    end

    logic [RW-1:0] r_last;
    logic          round_up;
    logic [F:0]    value;
    out_t          out_next;

    always_comb begin
        r_last   = {r_reg[F-1][RW-2:0], 1'b0};
        round_up = r_last >= {1'b0, d_reg[F-1]};
        if (full_reg[F-1]) begin
            value = (F + 1)'(1) << F;
        end else begin
            value = {1'b0, q_reg[F-1]} + (F + 1)'(round_up);
        end
        out_next.hit            = hit_reg[F-1];
        out_next.entry_fraction = hit_reg[F-1] ? value : '0;
    end

    always_ff @(posedge aclk) begin
        if (en[F]) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### sv/segment_box_slab_intersect_core.sv
// Segment versus axis-aligned box test by the slab method, exact in fixed
// point. One item is accepted every cycle unless the output stalls back to
// the input. Items pass through FRACTION_BITS + 6 register stages: one lane
// stage, three stages of split cross-product comparison, one merge stage,
// and a restoring division pipeline that yields one bit of the entry
// fraction a stage plus a rounding stage. Every stage holds its item
// independently, so a stalled output only stops the unbroken run of full
// stages behind it.
// Uses sbsi_pkg and the sbsi lane, compare, merge and fraction modules.
`timescale 1ns / 1ps
`default_nettype none

module segment_box_slab_intersect_core
    import sbsi_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  in_t       s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int NS = FRACTION_BITS + 6;

    logic [NS-1:0] valid_reg, valid_next, en;

    always_comb begin
        en[NS-1] = !valid_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[NS-1];

    logic signed [COORD_WIDTH-1:0] p0 [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] p1 [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] c  [NUM_AXES];
    logic [COORD_WIDTH-2:0]        h  [NUM_AXES];

    always_comb begin
        p0[0] = s_data.start_x;      p0[1] = s_data.start_y;      p0[2] = s_data.start_z;
        p1[0] = s_data.end_x;        p1[1] = s_data.end_y;        p1[2] = s_data.end_z;
        c[0]  = s_data.box_center_x; c[1]  = s_data.box_center_y; c[2]  = s_data.box_center_z;
        h[0]  = s_data.box_half_x;   h[1]  = s_data.box_half_y;   h[2]  = s_data.box_half_z;
    end

    lane_t lane_reg [NUM_AXES];

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        sbsi_lane u_lane (
            .aclk     (aclk),
            .en       (en[0]),
            .p0       (p0[a]),
            .p1       (p1[a]),
            .c        (c[a]),
            .h        (h[a]),
            .lane_reg (lane_reg[a])
        );
    end

    cmp_res_t res;

    for (genvar k = 0; k < NUM_CROSS; k++) begin : g_cross
        logic unused_lt;
        sbsi_cmp u_cmp (
            .aclk   (aclk),
            .en     (en[3:1]),
            .an     (lane_reg[CROSS_LO[k]].n1),
            .ad     (lane_reg[CROSS_LO[k]].den),
            .bn     (lane_reg[CROSS_HI[k]].n2),
            .bd     (lane_reg[CROSS_HI[k]].den),
            .gt_reg (res.cross_gt[k]),
            .lt_reg (unused_lt)
        );
    end

    for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
        sbsi_cmp u_cmp (
            .aclk   (aclk),
            .en     (en[3:1]),
            .an     (lane_reg[PAIR_A[p]].n1),
            .ad     (lane_reg[PAIR_A[p]].den),
            .bn     (lane_reg[PAIR_B[p]].n1),
            .bd     (lane_reg[PAIR_B[p]].den),
            .gt_reg (res.low_gt[p]),
            .lt_reg (res.low_lt[p])
        );
    end

    // Lane results ride alongside the comparison stages.
    lane_t lane_d1_reg [NUM_AXES];
    lane_t lane_d2_reg [NUM_AXES];
    lane_t lane_d3_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (en[1]) lane_d1_reg <= lane_reg;
        if (en[2]) lane_d2_reg <= lane_d1_reg;
        if (en[3]) lane_d3_reg <= lane_d2_reg;
    end

    sel_t sel_reg;

    sbsi_merge u_merge (
        .aclk    (aclk),
        .en      (en[4]),
        .lanes   (lane_d3_reg),
        .res     (res),
        .sel_reg (sel_reg)
    );

    sbsi_frac u_frac (
        .aclk    (aclk),
        .en      (en[NS-1:5]),
        .sel     (sel_reg),
        .out_reg (m_data)
    );

endmodule

`default_nettype wire

### sv/sbsi_checker.sv
// Port-level checker for the slab test core, attached by the bind below.
// Uses sbsi_pkg; watches only the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module sbsi_checker
    import sbsi_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input out_t      m_data
);

    localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.entry_fraction == '0)
        else $error("miss with nonzero fraction");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_fraction <= ONE)
        else $error("fraction above one");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind segment_box_slab_intersect_core sbsi_checker u_sbsi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

### tb/slab_result_checker.sv
// Checker for the segment versus box slab test: watches both channels,
// predicts each result with an exact rational slab model and compares.
// Depends on sbsi_pkg.
`timescale 1ns / 1ps

module slab_result_checker
    import sbsi_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   fail_count,
    output int   pending_count
);

    out_t expected_q[$];

    // Sign of an/ad - bn/bd for positive denominators; operands fit in 35 bits.
    function automatic int ratio_cmp(longint an, longint ad, longint bn, longint bd);
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        lhs = 128'(an) * 128'(bd);
        rhs = 128'(bn) * 128'(ad);
        if (lhs > rhs) return 1;
        if (lhs < rhs) return -1;
        return 0;
    endfunction

    // Rounded n/d in Q1.FRACTION_BITS, ties up, 0 <= n <= d.
    function automatic logic [FRACTION_BITS:0] round_fraction(longint n, longint d);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        if (n >= d) return (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
        num = 128'(n) << FRACTION_BITS;
        q = num / 128'(d);
        r = num % 128'(d);
        if ((r << 1) >= 128'(d)) q = q + 128'(1);
        return q[FRACTION_BITS:0];
    endfunction

    function automatic out_t predict_slab_hit(in_t item);
        longint p0[3];
        longint p1[3];
        longint c[3];
        longint h[3];
        longint lo, hi, dir, n1, n2, den, t;
        longint tmin_n, tmin_d, tmax_n, tmax_d;
        logic hit;
        out_t res;
        p0 = '{longint'(item.start_x), longint'(item.start_y), longint'(item.start_z)};
        p1 = '{longint'(item.end_x), longint'(item.end_y), longint'(item.end_z)};
        c = '{longint'(item.box_center_x), longint'(item.box_center_y),
              longint'(item.box_center_z)};
        h = '{longint'({1'b0, item.box_half_x}), longint'({1'b0, item.box_half_y}),
              longint'({1'b0, item.box_half_z})};
        tmin_n = 0; tmin_d = 1; tmax_n = 1; tmax_d = 1;
        hit = 1'b1;
        for (int a = 0; a < 3 && hit; a++) begin
            lo = c[a] - h[a];
            hi = c[a] + h[a];
            dir = p1[a] - p0[a];
            if (dir == 0) begin
                if (p0[a] < lo || p0[a] > hi) hit = 1'b0;
            end else begin
                n1 = lo - p0[a];
                n2 = hi - p0[a];
                den = dir;
                if (den < 0) begin
                    den = -den; n1 = -n1; n2 = -n2;
                end
                if (n1 > n2) begin
                    t = n1; n1 = n2; n2 = t;
                end
                if (ratio_cmp(n1, den, tmin_n, tmin_d) > 0) begin
                    tmin_n = n1; tmin_d = den;
                end
                if (ratio_cmp(n2, den, tmax_n, tmax_d) < 0) begin
                    tmax_n = n2; tmax_d = den;
                end
                if (ratio_cmp(tmin_n, tmin_d, tmax_n, tmax_d) > 0) hit = 1'b0;
            end
        end
        res.hit = hit;
        res.entry_fraction = hit ? round_fraction(tmin_n, tmin_d) : '0;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
    end

    assign pending_count = expected_q.size();

    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_q.push_back(predict_slab_hit(s_data));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.hit !== want.hit)
                        report_mismatch("hit", m_data.hit, want.hit);
                    if (m_data.entry_fraction !== want.entry_fraction)
                        report_mismatch("entry_fraction", m_data.entry_fraction,
                                        want.entry_fraction);
                end
            end
        end
    end

endmodule

### tb/tb_segment_box_slab_intersect_core.sv
// Top of the slab test bench: clock, reset, directed and random segments,
// random gaps on both channels. Depends on sbsi_pkg, the core and
// slab_result_checker.
`timescale 1ns / 1ps

module tb_segment_box_slab_intersect_core;
    import sbsi_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int LATENCY      = FRACTION_BITS + 6;
    localparam int LONG_HOLD    = 200;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    int   fail_count;
    int   pending_count;
    logic hold_release;
    logic hold_request;

    segment_box_slab_intersect_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    slab_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Random coordinate: mostly near small boxes, sometimes any 32-bit value.
    function automatic logic [31:0] rand_coord(int base, bit wide);
        if (wide) return $urandom;
        return 32'(base + $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
    endfunction

    function automatic in_t random_segment();
        in_t item;
        bit wide;
        int cx, cy, cz;
        wide = ($urandom_range(0, 9) == 0);
        cx = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        cy = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        cz = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        item.box_center_x = wide ? $urandom : cx;
        item.box_center_y = wide ? $urandom : cy;
        item.box_center_z = wide ? $urandom : cz;
        item.box_half_x = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h0002_0000));
        item.box_half_y = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h0002_0000));
        item.box_half_z = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h0002_0000));
        item.start_x = rand_coord(cx, wide);
        item.start_y = rand_coord(cy, wide);
        item.start_z = rand_coord(cz, wide);
        item.end_x = rand_coord(cx, wide);
        item.end_y = rand_coord(cy, wide);
        item.end_z = rand_coord(cz, wide);
        // Axis-parallel segments exercise the containment test.
        if ($urandom_range(0, 4) == 0) item.end_x = item.start_x;
        if ($urandom_range(0, 4) == 0) item.end_y = item.start_y;
        if ($urandom_range(0, 4) == 0) item.end_z = item.start_z;
        return item;
    endfunction

    function automatic in_t make_segment(int sx, int sy, int sz, int ex, int ey, int ez,
                                         int hx, int hy, int hz);
        in_t item;
        item.start_x = sx; item.start_y = sy; item.start_z = sz;
        item.end_x = ex; item.end_y = ey; item.end_z = ez;
        item.box_center_x = 0; item.box_center_y = 0; item.box_center_z = 0;
        item.box_half_x = 31'(hx); item.box_half_y = 31'(hy); item.box_half_z = 31'(hz);
        return item;
    endfunction

    // Valid stays high after the handshake so that items can follow back to back;
    // callers drop it before any idle cycle.
    task automatic send_item(in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_with_gap(in_t item);
        int gap;
        send_item(item);
        gap = gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Receiver: random stalls, and one long hold-off on request.
    initial begin
        int stall;
        m_ready = 1'b0;
        hold_release = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request && !hold_release) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_release <= 1'b1;
            end
            stall = gap_length();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        in_t item;
        int wait_cycles;
        s_valid = 1'b0;
        s_data = '0;
        hold_request = 1'b0;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Clean hit through the middle, miss beside the box, start inside.
        send_item(make_segment(-32'sh50000, 0, 0, 32'sh50000, 0, 0, 32'h10000, 32'h10000,
                               32'h10000));
        send_item(make_segment(-32'sh50000, 32'sh30000, 0, 32'sh50000, 32'sh30000, 0,
                               32'h10000, 32'h10000, 32'h10000));
        send_item(make_segment(0, 0, 0, 32'sh50000, 32'sh10000, 0, 32'h10000, 32'h10000,
                               32'h10000));
        // Zero-length segments inside, on a face and outside.
        send_item(make_segment(32'sh8000, 0, 0, 32'sh8000, 0, 0, 32'h10000, 32'h10000,
                               32'h10000));
        send_item(make_segment(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000,
                               32'sh10000, 32'h10000, 32'h10000, 32'h10000));
        send_item(make_segment(32'sh10001, 0, 0, 32'sh10001, 0, 0, 32'h10000, 32'h10000,
                               32'h10000));
        // Segment ending exactly on a face, tangent along an edge, reverse direction.
        send_item(make_segment(-32'sh30000, 0, 0, -32'sh10000, 0, 0, 32'h10000, 32'h10000,
                               32'h10000));
        send_item(make_segment(-32'sh30000, 32'sh10000, 32'sh10000, 32'sh30000, 32'sh10000,
                               32'sh10000, 32'h10000, 32'h10000, 32'h10000));
        send_item(make_segment(32'sh30000, 32'sh2000, 0, -32'sh30000, -32'sh2000, 0,
                               32'h10000, 32'h10000, 32'h10000));
        // Corner touch on a diagonal and a segment ending just past the top face.
        send_item(make_segment(-32'sh20000, -32'sh20000, -32'sh20000, 0, 0, 0, 32'h10000,
                               32'h10000, 32'h10000));
        send_item(make_segment(-32'sh20000, -32'sh10000, 0, 0, 32'sh10001, 0, 32'h10000,
                               32'h10000, 32'h10000));
        // Zero-size box, ending short of the box, a smallest nonzero entry fraction, start in the largest box.
        send_item(make_segment(-32'sh10000, 0, 0, 32'sh10000, 0, 0, 0, 0, 0));
        send_item(make_segment(-32'sh30000, 0, 0, -32'sh20000, 0, 0, 32'h10000, 32'h10000,
                               32'h10000));
        send_item(make_segment(-3, 0, 0, 32'sh1fffd, 0, 0, 1, 1, 1));
        send_item(make_segment(0, 0, 0, 3, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        // Extremes of every field.
        item = '1;
        send_item(item);
        item = '0;
        send_item(item);
        item.start_x = 32'h8000_0000; item.start_y = 32'h8000_0000;
        item.start_z = 32'h8000_0000;
        item.end_x = 32'h7fff_ffff; item.end_y = 32'h7fff_ffff; item.end_z = 32'h7fff_ffff;
        item.box_center_x = 32'h7fff_ffff; item.box_center_y = 32'h8000_0000;
        item.box_center_z = 32'h7fff_ffff;
        item.box_half_x = '1; item.box_half_y = '1; item.box_half_z = '1;
        send_item(item);
        item.end_x = 32'h8000_0000; item.start_x = 32'h7fff_ffff;
        item.box_center_x = 32'h8000_0000; item.box_half_y = '0;
        send_item(item);

        // Long output hold-off while items keep coming, so the input stalls.
        hold_request <= 1'b1;
        for (int i = 0; i < 80; i++) send_item(random_segment());
        s_valid <= 1'b0;
        @(posedge aclk);
        while (!hold_release) @(posedge aclk);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                // Let the pipe drain fully before going on.
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_count != 0) @(posedge aclk);
            end
            if (i % 200 < 40) send_item(random_segment());
            else send_with_gap(random_segment());
        end
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
